// ===== design/dmbc_pkg.sv =====
// ---------------------------------------------------------------------------
// dmbc_pkg
// Shared types, codes and widths of the dual motor bridge controller.
// ---------------------------------------------------------------------------
package dmbc_pkg;

  localparam int CHANNELS_DEF = 2;

  localparam int KIND_W   = 2;
  localparam int MODE_W   = 2;
  localparam int DIR_W    = 2;
  localparam int CMD_W    = 16;
  localparam int LIMIT_W  = 15;
  localparam int DUTY_W   = 16;
  localparam int SPEED_W  = 32;
  localparam int POS_W    = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LIMIT_W-1:0] DUTY_LIMIT_RST = LIMIT_W'(1000);
  localparam logic [DUTY_W-1:0]  BRAKE_DUTY_RST = DUTY_W'(1000);

  // item kinds
  localparam logic [KIND_W-1:0] KIND_INIT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DUTY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TICK = 2'd3;

  // bridge modes
  localparam logic [MODE_W-1:0] MODE_COAST = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BRAKE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DRIVE = 2'd2;

  // rotation directions
  localparam logic [DIR_W-1:0] DIR_ZERO = 2'd0;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRAKE_DUTY = 2'd1;

  // pin patterns, bit 0 is bridge input one
  localparam logic [1:0] PINS_LOW   = 2'b00;
  localparam logic [1:0] PINS_FWD   = 2'b01;
  localparam logic [1:0] PINS_REV   = 2'b10;
  localparam logic [1:0] PINS_BRAKE = 2'b11;

  typedef struct packed {
    logic [LIMIT_W-1:0] duty_limit;
    logic [DUTY_W-1:0]  brake_duty;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic                      channel;
    logic [MODE_W-1:0]         mode;
    logic signed [CMD_W-1:0]   duty_command;
    logic signed [SPEED_W-1:0] enc_delta;
    logic                      encoder_ok;
    logic                      hw_ok;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [DIR_W-1:0]          last_dir;
    logic                      pend;
    logic signed [CMD_W-1:0]   pend_duty;
    logic signed [SPEED_W-1:0] speed;
    logic signed [POS_W-1:0]   position;
    logic                      ready;
    logic [1:0]                pins;
    logic [DUTY_W-1:0]         duty;
  } chan_state_t;

  typedef struct packed {
    logic                      out_channel;
    logic                      bridge_in1;
    logic                      bridge_in2;
    logic [DUTY_W-1:0]         pwm_duty;
    logic signed [SPEED_W-1:0] speed;
    logic signed [POS_W-1:0]   position;
    logic                      channel_ready;
    logic                      crossing_pending;
  } result_t;

endpackage

// ===== design/dmbc_intf.sv =====
// ---------------------------------------------------------------------------
// dmbc_intf
// Request, result and configuration channels of the motor bridge controller.
// ---------------------------------------------------------------------------
interface dmbc_in_if
  import dmbc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [KIND_W-1:0]         kind;
  logic                      channel;
  logic [MODE_W-1:0]         mode;
  logic signed [CMD_W-1:0]   duty_command;
  logic signed [SPEED_W-1:0] enc_delta;
  logic                      encoder_ok;
  logic                      hw_ok;

  modport source (output valid, kind, channel, mode, duty_command, enc_delta,
                  encoder_ok, hw_ok, input ready);
  modport sink   (input valid, kind, channel, mode, duty_command, enc_delta,
                  encoder_ok, hw_ok, output ready);
endinterface

interface dmbc_out_if
  import dmbc_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic                      out_channel;
  logic                      bridge_in1;
  logic                      bridge_in2;
  logic [DUTY_W-1:0]         pwm_duty;
  logic signed [SPEED_W-1:0] speed;
  logic signed [POS_W-1:0]   position;
  logic                      channel_ready;
  logic                      crossing_pending;

  modport source (output valid, out_channel, bridge_in1, bridge_in2, pwm_duty, speed,
                  position, channel_ready, crossing_pending, input ready);
  modport sink   (input valid, out_channel, bridge_in1, bridge_in2, pwm_duty, speed,
                  position, channel_ready, crossing_pending, output ready);
endinterface

interface dmbc_cfg_if
  import dmbc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/dmbc_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// dmbc_cfg_regs
// Duty limit and brake duty registers, written over the configuration channel.
// ---------------------------------------------------------------------------
module dmbc_cfg_regs
  import dmbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic [CFG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      // writes to unknown indexes are dropped
      if (wr_index == REG_DUTY_LIMIT) begin
        cfg_nxt.duty_limit = wr_data[LIMIT_W-1:0];
      end else if (wr_index == REG_BRAKE_DUTY) begin
        cfg_nxt.brake_duty = wr_data[DUTY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_limit <= DUTY_LIMIT_RST;
      cfg_r.brake_duty <= BRAKE_DUTY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/dmbc_step.sv =====
// ---------------------------------------------------------------------------
// dmbc_step
// Next channel state and result for one request, from the current state.
// ---------------------------------------------------------------------------
module dmbc_step
  import dmbc_pkg::*;
(
  input  item_t       item,
  input  chan_state_t cur,
  input  cfg_t        cfg,
  output chan_state_t nxt,
  output result_t     res
);

  function automatic logic signed [CMD_W-1:0] clamp_cmd(logic signed [CMD_W-1:0] v,
                                                        logic [LIMIT_W-1:0] lim);
    logic signed [CMD_W:0] lim_pos;
    logic signed [CMD_W:0] lim_neg;
    logic signed [CMD_W:0] v_ext;
    lim_pos = {2'b00, lim};
    lim_neg = -lim_pos;
    v_ext   = {v[CMD_W-1], v};
    if (v_ext > lim_pos) return lim_pos[CMD_W-1:0];
    if (v_ext < lim_neg) return lim_neg[CMD_W-1:0];
    return v;
  endfunction

  function automatic chan_state_t drive_cmd(chan_state_t s, logic signed [CMD_W-1:0] v);
    chan_state_t o;
    logic signed [CMD_W:0] neg;
    o = s;
    neg = -{v[CMD_W-1], v};
    if (s.ready) begin
      if (v > 0) begin
        o.pins = PINS_FWD;
        o.duty = DUTY_W'(v);
      end else if (v < 0) begin
        o.pins = PINS_REV;
        o.duty = neg[DUTY_W-1:0];
      end else begin
        o.pins = PINS_LOW;
        o.duty = '0;
      end
    end
    o.last_dir = (v > 0) ? DIR_FWD : (v < 0) ? DIR_REV : DIR_ZERO;
    return o;
  endfunction

  logic signed [CMD_W-1:0] clamped;
  logic [DIR_W-1:0]        new_dir;
  logic                    reversal;

  always_comb begin
    clamped = clamp_cmd(item.duty_command, cfg.duty_limit);
    new_dir = (clamped > 0) ? DIR_FWD : (clamped < 0) ? DIR_REV : DIR_ZERO;
    reversal = (cur.last_dir != DIR_ZERO) && (new_dir != DIR_ZERO) &&
               (cur.last_dir != new_dir);
  end

  always_comb begin
    nxt = cur;
    unique case (item.kind)
      KIND_INIT: begin
        nxt = '0;
        nxt.ready = item.hw_ok;
      end
      KIND_MODE: begin
        if (item.mode == MODE_BRAKE) begin
          nxt.mode = MODE_BRAKE;
          nxt.pend = 1'b0;
          nxt.pins = PINS_BRAKE;
          if (cur.ready) nxt.duty = cfg.brake_duty;
        end else if (item.mode == MODE_COAST) begin
          nxt.mode = MODE_COAST;
          nxt.pend = 1'b0;
          nxt.pins = PINS_LOW;
          if (cur.ready) nxt.duty = '0;
        end else if (item.mode == MODE_DRIVE) begin
          nxt.mode = MODE_DRIVE;
          nxt.pend = 1'b0;
        end
      end
      KIND_DUTY: begin
        if (cur.ready && cur.mode == MODE_DRIVE) begin
          if (reversal) begin
            // coast through the zero crossing, drive on the next good tick
            nxt.pins      = PINS_LOW;
            nxt.duty      = '0;
            nxt.pend      = 1'b1;
            nxt.pend_duty = clamped;
            nxt.last_dir  = new_dir;
          end else if (!cur.pend) begin
            nxt = drive_cmd(cur, clamped);
          end else begin
            nxt.pend_duty = clamped;
          end
        end
      end
      KIND_TICK: begin
        if (!cur.ready) begin
          nxt.speed = '0;
        end else if (item.encoder_ok) begin
          nxt.speed    = item.enc_delta;
          nxt.position = cur.position + POS_W'(item.enc_delta);
          if (cur.pend) begin
            nxt.pend = 1'b0;
            // limit may have changed while the command waited
            if (cur.mode == MODE_DRIVE) begin
              nxt = drive_cmd(nxt, clamp_cmd(cur.pend_duty, cfg.duty_limit));
            end
          end
        end else begin
          nxt.ready = 1'b0;
          nxt.speed = '0;
        end
      end
      default: nxt = cur;
    endcase
  end

  always_comb begin
    res.out_channel      = item.channel;
    res.bridge_in1       = nxt.pins[0];
    res.bridge_in2       = nxt.pins[1];
    res.pwm_duty         = nxt.duty;
    res.speed            = nxt.speed;
    res.position         = nxt.position;
    res.channel_ready    = nxt.ready;
    res.crossing_pending = nxt.pend;
  end

endmodule

// ===== design/dual_motor_bridge_controller.sv =====
// ---------------------------------------------------------------------------
// dual_motor_bridge_controller
// H-bridge controller for several motor channels with zero-cross coasting.
// ---------------------------------------------------------------------------
// in_if carries requests: init, set mode, set duty or tick, each addressing
// one channel. Every request yields exactly one result on out_if holding the
// channel's pins, PWM duty, speed, 64-bit position, readiness and whether a
// reversed command still waits for a tick. A request for a channel beyond
// CHANNELS changes nothing and returns zeros beside its channel number.
// cfg_if writes the duty limit (index 0) and brake duty (index 1); it is
// always ready and should be written only while no request is in flight.
// A request waits in the input register until the output register is empty
// or being read; then its combinationally computed result is loaded there.
// One request per cycle is taken while out_if does not stall, and requests
// for the same channel may follow each other directly, as channel state is
// updated between the registers. While out_if stalls, one more request is
// taken into the input register, then in_if.ready drops until the result
// is taken. Reset empties both registers, restores the configuration
// defaults and puts every channel in coast, not ready, position zero.
// ---------------------------------------------------------------------------
module dual_motor_bridge_controller
  import dmbc_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dmbc_in_if.sink    in_if,
  dmbc_out_if.source out_if,
  dmbc_cfg_if.sink   cfg_if
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t cfg;

  dmbc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_if.valid && cfg_if.ready),
    .wr_index (cfg_if.index),
    .wr_data  (cfg_if.data),
    .cfg      (cfg)
  );

  assign cfg_if.ready = 1'b1;

  // input register
  logic        in_valid_r, in_valid_nxt;
  item_t       item_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     res_r;
  logic        advance;
  logic        in_take;

  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;
  assign in_take     = in_if.valid && in_if.ready;

  always_comb begin
    in_valid_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_r);
    out_valid_nxt = advance ? 1'b1 : ((out_valid_r && out_if.ready) ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.kind          <= in_if.kind;
      item_r.channel       <= in_if.channel;
      item_r.mode          <= in_if.mode;
      item_r.duty_command  <= in_if.duty_command;
      item_r.enc_delta     <= in_if.enc_delta;
      item_r.encoder_ok    <= in_if.encoder_ok;
      item_r.hw_ok         <= in_if.hw_ok;
    end
  end

  // per-channel state
  chan_state_t st_r [CHANNELS];
  chan_state_t cur;
  chan_state_t st_nxt;
  result_t     step_res;
  result_t     res_nxt;
  logic [CH_W-1:0] ch_idx;
  logic        in_range;

  assign ch_idx   = CH_W'(item_r.channel);
  assign in_range = (32'(item_r.channel) < CHANNELS);
  assign cur      = in_range ? st_r[ch_idx] : '0;

  dmbc_step u_step (
    .item (item_r),
    .cur  (cur),
    .cfg  (cfg),
    .nxt  (st_nxt),
    .res  (step_res)
  );

  always_comb begin
    if (in_range) begin
      res_nxt = step_res;
    end else begin
      res_nxt = '0;
      res_nxt.out_channel = item_r.channel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st_r[i] <= '0;
      end
    end else if (advance && in_range) begin
      st_r[ch_idx] <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.out_channel      = res_r.out_channel;
  assign out_if.bridge_in1       = res_r.bridge_in1;
  assign out_if.bridge_in2       = res_r.bridge_in2;
  assign out_if.pwm_duty         = res_r.pwm_duty;
  assign out_if.speed            = res_r.speed;
  assign out_if.position         = res_r.position;
  assign out_if.channel_ready    = res_r.channel_ready;
  assign out_if.crossing_pending = res_r.crossing_pending;

  // a request leaving the input register always shows up as a result
  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("request left input register without a result");

  // input backpressure only from a full pipe behind a stalled receiver
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (in_valid_r && out_valid_r && !out_if.ready))
    else $error("input stalled with room in the pipe");

  // a pending reversal is never held while braking
  a_no_pending_in_brake: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(res_r.bridge_in1 && res_r.bridge_in2 && res_r.crossing_pending))
    else $error("crossing pending with bridge braked");

  // results for absent channels carry no state
  a_absent_channel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (32'(res_r.out_channel) >= CHANNELS)) |->
      (res_r.pwm_duty == '0 && res_r.position == '0 && !res_r.channel_ready))
    else $error("result for absent channel not zero");

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the dual motor bridge controller. Requests go in
// through a handshake driver. A shadow model of both channels predicts each
// status result, and a monitor compares every returned field against it.
// Covered: directed corner cases, configuration extremes, random traffic
// under several idle mixes, and a long output stall.
// ---------------------------------------------------------------------------
module testbench;
  import dmbc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCHAN = CHANNELS_DEF;
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  logic clk;
  logic rst_n;

  dmbc_in_if  in_if();
  dmbc_out_if out_if();
  dmbc_cfg_if cfg_if();

  dual_motor_bridge_controller u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // shadow of the block
  cfg_t        cfg_shadow;
  chan_state_t chan_shadow [NCHAN];
  result_t     status_q [$];

  int errors;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_cycles;
  int kind_count [4];
  int results_checked;
  int cfg_writes;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // ---------------- prediction ----------------

  function automatic int limit_command(int cmd);
    int lim;
    lim = int'(cfg_shadow.duty_limit);
    if (cmd > lim) return lim;
    if (cmd < -lim) return -lim;
    return cmd;
  endfunction

  function automatic logic [DIR_W-1:0] direction_of(int v);
    if (v > 0) return DIR_FWD;
    if (v < 0) return DIR_REV;
    return DIR_ZERO;
  endfunction

  function automatic void coast_bridge(inout chan_state_t s);
    s.pins = PINS_LOW;
    if (s.ready) s.duty = '0;
  endfunction

  function automatic void drive_bridge(inout chan_state_t s, input int cmd);
    int v;
    logic [DIR_W-1:0] d;
    v = limit_command(cmd);
    d = direction_of(v);
    if (s.ready) begin
      if (d == DIR_FWD) begin
        s.pins = PINS_FWD;
        s.duty = DUTY_W'(v);
      end else if (d == DIR_REV) begin
        s.pins = PINS_REV;
        s.duty = DUTY_W'(-v);
      end else begin
        s.pins = PINS_LOW;
        s.duty = '0;
      end
    end
    s.last_dir = d;
  endfunction

  function automatic result_t apply_request(item_t rq);
    chan_state_t s;
    result_t r;
    int v;
    logic [DIR_W-1:0] d;
    s = chan_shadow[rq.channel];
    case (rq.kind)
      KIND_INIT: begin
        s.mode      = MODE_COAST;
        s.last_dir  = DIR_ZERO;
        s.pend      = 1'b0;
        s.pend_duty = '0;
        s.speed     = '0;
        s.position  = '0;
        s.ready     = rq.hw_ok;
        s.pins      = PINS_LOW;
        s.duty      = '0;
      end
      KIND_MODE: begin
        if (rq.mode != MODE_RESERVED) begin
          s.mode = rq.mode;
          s.pend = 1'b0;
          if (rq.mode == MODE_BRAKE) begin
            s.pins = PINS_BRAKE;
            if (s.ready) s.duty = cfg_shadow.brake_duty;
          end else if (rq.mode == MODE_COAST) begin
            coast_bridge(s);
          end
        end
      end
      KIND_DUTY: begin
        if (s.ready && s.mode == MODE_DRIVE) begin
          v = limit_command(int'(rq.duty_command));
          d = direction_of(v);
          // reversal: coast now, hold the command for the next tick
          if (s.last_dir != DIR_ZERO && d != DIR_ZERO && s.last_dir != d) begin
            coast_bridge(s);
            s.pend      = 1'b1;
            s.pend_duty = CMD_W'(v);
            s.last_dir  = d;
          end else if (!s.pend) begin
            drive_bridge(s, v);
          end else begin
            s.pend_duty = CMD_W'(v);
          end
        end
      end
      default: begin
        if (!s.ready) begin
          s.speed = '0;
        end else if (rq.encoder_ok) begin
          s.speed    = rq.enc_delta;
          s.position = s.position + {{(POS_W-SPEED_W){rq.enc_delta[SPEED_W-1]}},
                                     rq.enc_delta};
          if (s.pend) begin
            s.pend = 1'b0;
            if (s.mode == MODE_DRIVE) drive_bridge(s, int'(s.pend_duty));
          end
        end else begin
          s.ready = 1'b0;
          s.speed = '0;
        end
      end
    endcase
    chan_shadow[rq.channel] = s;
    r.out_channel      = rq.channel;
    r.bridge_in1       = s.pins[0];
    r.bridge_in2       = s.pins[1];
    r.pwm_duty         = s.duty;
    r.speed            = s.speed;
    r.position         = s.position;
    r.channel_ready    = s.ready;
    r.crossing_pending = s.pend;
    return r;
  endfunction

  // ---------------- drivers ----------------

  function automatic item_t make_request(logic [KIND_W-1:0] kind, int ch,
                                         logic [MODE_W-1:0] mode, int cmd, int delta,
                                         int enc_ok, int hw_ok);
    item_t rq;
    rq.kind          = kind;
    rq.channel       = 1'(ch);
    rq.mode          = mode;
    rq.duty_command  = CMD_W'(cmd);
    rq.enc_delta     = SPEED_W'(delta);
    rq.encoder_ok    = 1'(enc_ok);
    rq.hw_ok         = 1'(hw_ok);
    return rq;
  endfunction

  // called at a rising edge; returns at the edge where the request was taken
  task automatic send_request(item_t rq);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid         <= 1'b1;
    in_if.kind          <= rq.kind;
    in_if.channel       <= rq.channel;
    in_if.mode          <= rq.mode;
    in_if.duty_command  <= rq.duty_command;
    in_if.enc_delta     <= rq.enc_delta;
    in_if.encoder_ok    <= rq.encoder_ok;
    in_if.hw_ok         <= rq.hw_ok;
    do @(posedge clk); while (!in_if.ready);
    status_q.push_back(apply_request(rq));
    kind_count[rq.kind]++;
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    // output register latency
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx == REG_DUTY_LIMIT) cfg_shadow.duty_limit = data[LIMIT_W-1:0];
    else if (idx == REG_BRAKE_DUTY) cfg_shadow.brake_duty = data;
    cfg_writes++;
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] limit, logic [CFG_DATA_W-1:0] brake);
    wait_drain();
    write_reg(REG_DUTY_LIMIT, limit);
    write_reg(REG_BRAKE_DUTY, brake);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic item_t random_request();
    item_t rq;
    int pick;
    rq = '0;
    pick = $urandom_range(99);
    if (pick < 5) rq.kind = KIND_INIT;
    else if (pick < 20) rq.kind = KIND_MODE;
    else if (pick < 62) rq.kind = KIND_DUTY;
    else rq.kind = KIND_TICK;
    rq.channel = 1'($urandom_range(NCHAN - 1));
    rq.hw_ok = ($urandom_range(99) < 88);
    rq.encoder_ok = ($urandom_range(99) < 95);
    pick = $urandom_range(99);
    if (pick < 15) rq.mode = MODE_COAST;
    else if (pick < 30) rq.mode = MODE_BRAKE;
    else if (pick < 93) rq.mode = MODE_DRIVE;
    else rq.mode = MODE_RESERVED;
    case ($urandom_range(3))
      0: rq.duty_command = CMD_W'($urandom);
      1: rq.duty_command = CMD_W'(int'($urandom_range(1200)) * ($urandom_range(1) ? 1 : -1));
      2: rq.duty_command = CMD_W'(int'($urandom_range(40)) - 20);
      default: begin
        case ($urandom_range(3))
          0: rq.duty_command = 16'sh7FFF;
          1: rq.duty_command = 16'sh8000;
          2: rq.duty_command = 16'sh0000;
          default: rq.duty_command = 16'shFFFF;
        endcase
      end
    endcase
    case ($urandom_range(4))
      0: rq.enc_delta = SPEED_W'($urandom);
      1: rq.enc_delta = $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: rq.enc_delta = SPEED_W'(int'($urandom_range(2000)) - 1000);
    endcase
    return rq;
  endfunction

  // ---------------- result monitor ----------------

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (status_q.size() == 0) begin
        $error("result with no request outstanding, channel %0d", out_if.out_channel);
        errors++;
      end else begin
        want = status_q.pop_front();
        results_checked++;
        check_field("out_channel", want.out_channel, out_if.out_channel);
        check_field("bridge_in1", want.bridge_in1, out_if.bridge_in1);
        check_field("bridge_in2", want.bridge_in2, out_if.bridge_in2);
        check_field("pwm_duty", want.pwm_duty, out_if.pwm_duty);
        check_field("speed", want.speed, out_if.speed);
        check_field("position", want.position, out_if.position);
        check_field("channel_ready", want.channel_ready, out_if.channel_ready);
        check_field("crossing_pending", want.crossing_pending, out_if.crossing_pending);
      end
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    item_t seq [$];
    seq.push_back(make_request(KIND_TICK, 0, MODE_COAST, 0, 5, 1, 0));    // not ready
    seq.push_back(make_request(KIND_INIT, 0, MODE_COAST, 0, 0, 0, 1));
    seq.push_back(make_request(KIND_INIT, 1, MODE_COAST, 0, 0, 0, 0));    // hw failed
    seq.push_back(make_request(KIND_DUTY, 1, MODE_DRIVE, 100, 0, 0, 0));  // ignored
    seq.push_back(make_request(KIND_DUTY, 0, MODE_DRIVE, 100, 0, 0, 0));  // coast mode
    seq.push_back(make_request(KIND_MODE, 0, MODE_DRIVE, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, 32767, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, -32768, 0, 0, 0)); // reversal
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, 5, 0, 0, 0));
    seq.push_back(make_request(KIND_TICK, 0, MODE_COAST, 0, 32'h7FFFFFFF, 1, 0));
    seq.push_back(make_request(KIND_TICK, 0, MODE_COAST, 0, 32'h80000000, 1, 0));
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, -1, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 0, MODE_COAST, 1, 0, 0, 0));
    seq.push_back(make_request(KIND_MODE, 0, MODE_DRIVE, 0, 0, 0, 0));   // drops pending
    seq.push_back(make_request(KIND_TICK, 0, MODE_COAST, 0, -1, 1, 0));
    seq.push_back(make_request(KIND_MODE, 0, MODE_BRAKE, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_MODE, 0, MODE_RESERVED, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_MODE, 0, MODE_COAST, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_TICK, 0, MODE_COAST, 0, 77, 0, 0));   // encoder fail
    seq.push_back(make_request(KIND_MODE, 1, MODE_BRAKE, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_INIT, 1, MODE_COAST, 0, 0, 0, 1));
    seq.push_back(make_request(KIND_MODE, 1, MODE_DRIVE, 0, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 1, MODE_COAST, -300, 0, 0, 0));
    seq.push_back(make_request(KIND_DUTY, 1, MODE_COAST, 300, 0, 0, 0));
    seq.push_back(make_request(KIND_TICK, 1, MODE_COAST, 0, 0, 1, 0));
    foreach (seq[i]) send_request(seq[i]);
  endtask

  task automatic test_config_extremes();
    logic [CFG_DATA_W-1:0] limits [4];
    logic [CFG_DATA_W-1:0] brakes [4];
    limits = '{16'h8000, 16'hFFFF, 16'h0001, 16'd1000};  // zero limit, max limit
    brakes = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5};
    for (int k = 0; k < 4; k++) begin
      configure(limits[k], brakes[k]);
      repeat (30) send_request(random_request());
    end
  endtask

  task automatic test_random_phase(int s_pct, int r_pct, int count);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    configure(CFG_DATA_W'($urandom_range(1, 2000)), CFG_DATA_W'($urandom));
    repeat (count) send_request(random_request());
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_drain();
    // receiver stops long enough for the input side to back up
    hold_cycles = 60;
    repeat (24) send_request(random_request());
    wait_drain();
    recv_idle_pct = 50;
    repeat (16) send_request(random_request());
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_INIT;
    in_if.channel = 1'b0;
    in_if.mode = MODE_COAST;
    in_if.duty_command = '0;
    in_if.enc_delta = '0;
    in_if.encoder_ok = 1'b0;
    in_if.hw_ok = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_DUTY_LIMIT;
    cfg_if.data = '0;
    cfg_shadow.duty_limit = DUTY_LIMIT_RST;
    cfg_shadow.brake_duty = BRAKE_DUTY_RST;
    for (int c = 0; c < NCHAN; c++) begin
      chan_shadow[c] = '0;
      chan_shadow[c].mode = MODE_COAST;
      chan_shadow[c].last_dir = DIR_ZERO;
      chan_shadow[c].pins = PINS_LOW;
    end
    errors = 0;
    hold_cycles = 0;
    send_idle_pct = 28;
    recv_idle_pct = 88;
    results_checked = 0;
    cfg_writes = 0;
    kind_count = '{0, 0, 0, 0};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_config_extremes();
    test_random_phase(28, 88, 380);
    test_random_phase(88, 28, 380);
    test_random_phase(0, 0, 380);
    test_output_stall();
    wait_drain();
    repeat (4) @(posedge clk);

    $display("covered %0d init, %0d mode, %0d duty, %0d tick requests",
             kind_count[KIND_INIT], kind_count[KIND_MODE],
             kind_count[KIND_DUTY], kind_count[KIND_TICK]);
    $display("checked %0d results across %0d register writes",
             results_checked, cfg_writes);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
